FILE: src/assert_macros.svh
// Assertion macros for the CIGAR indel extractor RTL.
// Clocked on clk, disabled while rst_n is low; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CIE_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CIE_ASSERT(lbl, prop, msg)
`define CIE_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: src/cie_pkg.sv
// Shared types, character codes and helpers for the CIGAR indel extractor.
// No dependencies.
package cie_pkg;

  localparam int COUNT_BITS_DEF = 28;
  localparam int START_W        = 31;
  localparam int POS_W          = 32;
  localparam int LEN_W          = 28;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 96;

  typedef logic [7:0] char_t;

  localparam char_t CHAR_0 = 8'h30;
  localparam char_t CHAR_9 = 8'h39;
  localparam char_t CHAR_M = 8'h4D;
  localparam char_t CHAR_N = 8'h4E;
  localparam char_t CHAR_S = 8'h53;
  localparam char_t CHAR_D = 8'h44;
  localparam char_t CHAR_I = 8'h49;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_CHAR  = 1'b1;
  localparam logic KIND_DEL = 1'b0;
  localparam logic KIND_INS = 1'b1;

  localparam logic [POS_W-1:0] LEN_MAX = 32'h0FFF_FFFF;

  typedef struct packed {
    logic               op;
    logic [START_W-1:0] read_start;
    char_t              cigar_char;
  } item_t;

  typedef struct packed {
    logic             indel_kind;
    logic [POS_W-1:0] ref_position;
    logic [LEN_W-1:0] indel_length;
    logic [POS_W-1:0] seq_offset;
  } result_t;

  // Saturating 32-bit add.
  function automatic logic [POS_W-1:0] sat_add32(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
  endfunction

  // True for a character item that reports an indel.
  function automatic logic is_event(item_t it);
    return (it.op == OP_CHAR) && ((it.cigar_char == CHAR_D) || (it.cigar_char == CHAR_I));
  endfunction

endpackage

FILE: src/cie_in_stage.sv
// Input register of the CIGAR indel extractor: holds one accepted item.
// Depends on cie_pkg.
module cie_in_stage
  import cie_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  take_i,
  output logic                  valid_o,
  output item_t                 item_o
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_tready = !valid_r || take_i;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.op         <= in_tuser;
      item_r.read_start <= in_tdata[START_W-1:0];
      item_r.cigar_char <= in_tdata[START_W+7:START_W];
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

FILE: src/cie_walker.sv
// CIGAR walk state (count, offsets, start) and the step logic that updates it on each fire.
// Depends on cie_pkg.
module cie_walker
  import cie_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t res_o
);

  localparam int ACC_W = COUNT_BITS + 4;

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0]      ref_off_r, ref_off_nxt;
  logic [POS_W-1:0]      read_off_r, read_off_nxt;
  logic [START_W-1:0]    start_r, start_nxt;

  logic [ACC_W-1:0]      acc;
  logic [COUNT_BITS-1:0] digit_cnt;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [POS_W-1:0]      cnt32;
  logic [POS_W-1:0]      ref_adv;
  logic [POS_W-1:0]      read_adv;

  assign is_digit = (item_i.cigar_char >= CHAR_0) && (item_i.cigar_char <= CHAR_9);
  assign digit    = 4'(item_i.cigar_char - CHAR_0);

  // count * 10 + digit, saturate when anything spills above COUNT_BITS
  assign acc = (ACC_W'(cnt_r) << 3) + (ACC_W'(cnt_r) << 1) + ACC_W'(digit);
  assign digit_cnt = (|acc[ACC_W-1:COUNT_BITS]) ? {COUNT_BITS{1'b1}} : acc[COUNT_BITS-1:0];

  assign cnt32    = POS_W'(cnt_r);
  assign ref_adv  = sat_add32(ref_off_r, cnt32);
  assign read_adv = sat_add32(read_off_r, cnt32);

  always_comb begin
    cnt_nxt      = cnt_r;
    ref_off_nxt  = ref_off_r;
    read_off_nxt = read_off_r;
    start_nxt    = start_r;
    priority if (item_i.op == OP_BEGIN) begin
      start_nxt    = item_i.read_start;
      cnt_nxt      = '0;
      ref_off_nxt  = '0;
      read_off_nxt = '0;
    end else if (is_digit) begin
      cnt_nxt = digit_cnt;
    end else begin
      cnt_nxt = '0;
      unique case (item_i.cigar_char)
        CHAR_M, CHAR_N: begin
          ref_off_nxt  = ref_adv;
          read_off_nxt = read_adv;
        end
        CHAR_S: read_off_nxt = read_adv;
        CHAR_D: ref_off_nxt  = ref_adv;
        CHAR_I: read_off_nxt = read_adv;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ref_off_r  <= '0;
      read_off_r <= '0;
      start_r    <= '0;
    end else if (fire_i) begin
      cnt_r      <= cnt_nxt;
      ref_off_r  <= ref_off_nxt;
      read_off_r <= read_off_nxt;
      start_r    <= start_nxt;
    end
  end

  // Event fields, taken from the state before this item's update.
  always_comb begin
    res_o.indel_kind   = (item_i.cigar_char == CHAR_I) ? KIND_INS : KIND_DEL;
    res_o.ref_position = sat_add32({1'b0, start_r}, ref_off_r);
    res_o.indel_length = (cnt32 > LEN_MAX) ? LEN_MAX[LEN_W-1:0] : cnt32[LEN_W-1:0];
    res_o.seq_offset   = (res_o.indel_kind == KIND_INS) ? read_off_r : '0;
  end

endmodule

FILE: src/cie_out_stage.sv
// Result register of the CIGAR indel extractor: holds one event until transfer.
// Depends on cie_pkg.
module cie_out_stage
  import cie_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_i,
  input  result_t                res_i,
  output logic                   free_o,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free_o = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.indel_kind;
  assign out_tdata  = {4'b0, res_r.seq_offset, res_r.indel_length, res_r.ref_position};

endmodule

FILE: src/cigar_indel_extractor_core.sv
// CIGAR indel extractor, top level. Uses cie_pkg, cie_in_stage, cie_walker, cie_out_stage.
// Flow: an accepted item is registered in the input stage, stepped through the walk
// state and its event (if any) is registered in the result stage, which drives out_tvalid.
// Throughput: one item per cycle, unless an event item waits for room in the result register.
// Reset: rst_n synchronous, active low; clears the valid flags of both stages and the
// count, offsets and start position.
`include "assert_macros.svh"

module cigar_indel_extractor_core
  import cie_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [30:0] read_start, [38:31] cigar_char, [39] zero
  input  logic                   in_tuser,   // [0] op
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] ref_position, [59:32] indel_length,
                                             // [91:60] seq_offset, [95:92] zero
  output logic                   out_tuser   // [0] indel_kind
);

  logic    in_valid;
  item_t   item;
  logic    produces;
  logic    out_free;
  logic    fire;
  logic    load;
  result_t res;

  // Hold each transfer in the input register.
  cie_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take_i    (fire),
    .valid_o   (in_valid),
    .item_o    (item)
  );

  // Step the held item when its event (if any) has room in the result register.
  // Items with no event never wait on the output side.
  assign produces = is_event(item);
  assign fire     = in_valid && (out_free || !produces);
  assign load     = fire && produces;

  cie_walker #(
    .COUNT_BITS (COUNT_BITS)
  ) u_walk (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire_i (fire),
    .item_i (item),
    .res_o  (res)
  );

  // Hold the event until the downstream transfer.
  cie_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (load),
    .res_i      (res),
    .free_o     (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // A pending, unaccepted event must never be overwritten.
  `CIE_ASSERT_NEVER(a_no_overwrite, out_tvalid && !out_tready && load, "event overwritten")
  // Only D and I character items load the result register.
  `CIE_ASSERT(a_load_is_event, load |-> (item.op == OP_CHAR && (item.cigar_char == CHAR_D || item.cigar_char == CHAR_I)), "load from non-event item")
  // A stepped event item shows up on the output in the next cycle.
  `CIE_ASSERT(a_event_shows, load |=> out_tvalid, "event lost after step")

endmodule

FILE: sim/cigar_indel_extractor_core_test.sv
// Self-checking bench for cigar_indel_extractor_core: CIGAR walks in, indel events out.
// Depends on cie_pkg for item/result types and character codes; needs nothing but the RTL.
`timescale 1ns / 100ps

module cigar_indel_extractor_core_test
  import cie_pkg::*;
;

  localparam int CNT_BITS = COUNT_BITS_DEF;
  localparam longint unsigned COUNT_MAX = (64'd1 << CNT_BITS) - 64'd1;
  localparam longint unsigned POS_MAX   = 64'hFFFF_FFFF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 200;  // cycles the sink refuses results once
  localparam int HOLD_TRIGGER = 400;  // input transfers before that hold starts
  localparam int DRAIN_WAIT   = 8;    // margin past the pipe stages
  localparam int RANDOM_ITEMS = 1750;

  // CIGAR letters the block does not act on; they only clear the count
  localparam char_t CHAR_EQ = 8'h3D;
  localparam char_t CHAR_X  = 8'h58;
  localparam char_t CHAR_H  = 8'h48;
  localparam char_t CHAR_P  = 8'h50;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [30:0] read_start, [38:31] cigar_char, [39] zero
  logic                   in_tuser;   // [0] op
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [31:0] ref_position, [59:32] indel_length,
                                      // [91:60] seq_offset, [95:92] zero
  logic                   out_tuser;  // [0] indel_kind

  int cycle_cnt = 0;

  // Walks the CIGAR stream alongside the block and queues the indels it must report.
  class indel_book;
    longint unsigned    count;
    logic [POS_W-1:0]   ref_off;
    logic [POS_W-1:0]   read_off;
    logic [START_W-1:0] start_pos;
    result_t            indels_due[$];
    int                 items_walked;
    int                 failures;
    int                 reports;

    function new();
      count = 0;
      ref_off = '0;
      read_off = '0;
      start_pos = '0;
      items_walked = 0;
      failures = 0;
      reports = 0;
    endfunction

    function logic [POS_W-1:0] add_sat(logic [POS_W-1:0] a, longint unsigned b);
      longint unsigned s;
      s = longint'(a) + b;
      return (s > POS_MAX) ? {POS_W{1'b1}} : s[POS_W-1:0];
    endfunction

    function int pending();
      return indels_due.size();
    endfunction

    function void walk_item(item_t it);
      longint unsigned cnt;
      longint unsigned d;
      result_t ev;
      items_walked++;
      cnt = count;
      if (it.op == OP_BEGIN) begin
        start_pos = it.read_start;
        count = 0;
        ref_off = '0;
        read_off = '0;
        return;
      end
      if (it.cigar_char >= CHAR_0 && it.cigar_char <= CHAR_9) begin
        d = longint'(it.cigar_char - CHAR_0);
        count = (cnt > (COUNT_MAX - d) / 10) ? COUNT_MAX : cnt * 10 + d;
        return;
      end
      count = 0;
      ev.ref_position = add_sat({1'b0, start_pos}, ref_off);
      ev.indel_length = LEN_W'((cnt > LEN_MAX) ? longint'(LEN_MAX) : cnt);
      case (it.cigar_char)
        CHAR_M, CHAR_N: begin
          ref_off = add_sat(ref_off, cnt);
          read_off = add_sat(read_off, cnt);
        end
        CHAR_S: begin
          read_off = add_sat(read_off, cnt);
        end
        CHAR_D: begin
          ev.indel_kind = KIND_DEL;
          ev.seq_offset = '0;
          indels_due = {indels_due, ev};
          ref_off = add_sat(ref_off, cnt);
        end
        CHAR_I: begin
          ev.indel_kind = KIND_INS;
          ev.seq_offset = read_off;
          indels_due = {indels_due, ev};
          read_off = add_sat(read_off, cnt);
        end
        default: ;
      endcase
    endfunction

    function void match_event(result_t got);
      result_t want;
      if (indels_due.size() == 0) begin
        failures++;
        if (reports < 10)
          $display("unexpected indel: kind %0d pos %0d len %0d seq %0d",
                   got.indel_kind, got.ref_position, got.indel_length, got.seq_offset);
        reports++;
        return;
      end
      want = indels_due.pop_front();
      if (got.indel_kind !== want.indel_kind || got.ref_position !== want.ref_position ||
          got.indel_length !== want.indel_length || got.seq_offset !== want.seq_offset) begin
        failures++;
        if (reports < 10)
          $display("indel mismatch: expected kind %0d pos %0d len %0d seq %0d,",
                   want.indel_kind, want.ref_position, want.indel_length, want.seq_offset,
                   " got kind %0d pos %0d len %0d seq %0d",
                   got.indel_kind, got.ref_position, got.indel_length, got.seq_offset);
        reports++;
      end
    endfunction
  endclass

  indel_book book;
  item_t     stim_q[$];

  cigar_indel_extractor_core #(
    .COUNT_BITS(CNT_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building. Unused fields of an item carry random junk so the block
  // is shown to ignore them: read_start on characters, cigar_char on begins.
  // ---------------------------------------------------------------------------
  function automatic void push_begin(logic [START_W-1:0] s);
    item_t it;
    it.op = OP_BEGIN;
    it.read_start = s;
    it.cigar_char = char_t'($urandom_range(0, 255));
    stim_q = {stim_q, it};
  endfunction

  function automatic void push_char(char_t c);
    item_t it;
    it.op = OP_CHAR;
    it.read_start = START_W'($urandom);
    it.cigar_char = c;
    stim_q = {stim_q, it};
  endfunction

  // Emit n as decimal digits, most significant first.
  function automatic void push_count(longint unsigned n);
    char_t digs[$];
    do begin
      digs.push_front(CHAR_0 + char_t'(n % 10));
      n = n / 10;
    end while (n != 0);
    foreach (digs[k]) push_char(digs[k]);
  endfunction

  function automatic void push_nines(int n);
    repeat (n) push_char(CHAR_9);
  endfunction

  function automatic logic [START_W-1:0] pick_start();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 35) return {START_W{1'b1}} - START_W'($urandom_range(0, 4000));
    return START_W'($urandom);
  endfunction

  function automatic char_t pick_letter();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CHAR_M;
    if (r < 40) return CHAR_N;
    if (r < 50) return CHAR_S;
    if (r < 70) return CHAR_D;
    if (r < 90) return CHAR_I;
    case ($urandom_range(0, 4))
      0: return CHAR_EQ;
      1: return CHAR_X;
      2: return CHAR_H;
      3: return CHAR_P;
      default: return char_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Count ahead of a letter: mostly short, sometimes absent, padded, huge or overflowing.
  function automatic void push_op_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return;
    if (r < 70) push_count($urandom_range(0, 999));
    else if (r < 80) begin
      push_char(CHAR_0);
      push_count($urandom_range(0, 99));
    end
    else if (r < 93) push_count($urandom_range(0, 32'h0FFF_FFFF));
    else push_nines($urandom_range(9, 12));
  endfunction

  // A long read of maximum counts drives both offsets and the position into saturation.
  function automatic void push_heavy_read();
    int r;
    push_begin(pick_start());
    repeat (26) begin
      push_count(COUNT_MAX);
      r = $urandom_range(0, 99);
      push_char(r < 60 ? CHAR_M : r < 75 ? CHAR_S : r < 88 ? CHAR_D : CHAR_I);
    end
  endfunction

  function automatic void build_directed();
    push_begin('0);
    push_char(CHAR_D);            // letters with no count report length zero
    push_char(CHAR_I);
    push_count(5);  push_char(CHAR_M);
    push_count(3);  push_char(CHAR_I);
    push_count(2);  push_char(CHAR_S);
    push_count(7);  push_char(CHAR_N);
    push_count(4);  push_char(CHAR_D);
    push_count(9);  push_char(CHAR_EQ);   // foreign letter drops the count
    push_char(CHAR_D);
    push_begin({START_W{1'b1}});
    push_nines(9);                // count saturates on the ninth digit
    push_char(CHAR_D);
    push_char(CHAR_I);
  endfunction

  function automatic void build_random();
    int reads;
    int r;
    int first;
    reads = 0;
    first = stim_q.size();
    while (stim_q.size() - first < RANDOM_ITEMS) begin
      reads++;
      r = $urandom_range(0, 99);
      if (reads == 5 || reads == 30 || r < 2) begin
        push_heavy_read();
      end else if (r < 12) begin
        // noise: raw characters, no begin in front
        repeat ($urandom_range(5, 15)) push_char(char_t'($urandom_range(0, 255)));
      end else begin
        if (r >= 17) push_begin(pick_start());  // a few reads run on without a begin
        repeat ($urandom_range(1, 12)) begin
          push_op_count();
          push_char(pick_letter());
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: drive at the falling edge, take the transfer at the rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(item_t it);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {1'b0, it.cigar_char, it.read_start};
    do @(posedge clk); while (!in_tready);
    book.walk_item(it);
  endtask

  // Send the queued items in bursts; some gaps are zero so long back-to-back runs occur.
  task automatic drive_queue();
    int burst;
    int gap;
    while (stim_q.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && stim_q.size() > 0) begin
        send_item(stim_q.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (book.pending() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: the sink changes tready at the falling edge. It switches between
  // always-ready, light and heavy random stalls and a fixed one-in-three pattern,
  // and once, after enough input transfers, holds off long enough to back up the
  // block so that in_tready must drop while items are still offered.
  // ---------------------------------------------------------------------------
  initial begin : sink
    int mode;
    int span;
    int tick;
    bit held;
    held = 1'b0;
    tick = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && book.items_walked >= HOLD_TRIGGER) begin
        held = 1'b1;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  // Check every result transfer against the oldest expected indel.
  always @(posedge clk) begin : watch_out
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.indel_kind   = out_tuser;
      got.ref_position = out_tdata[31:0];
      got.indel_length = out_tdata[59:32];
      got.seq_offset   = out_tdata[91:60];
      book.match_event(got);
    end
  end

  initial begin : run
    book = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    build_directed();
    drive_queue();
    // hold the sender until the directed indels are all out
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    build_random();
    drive_queue();
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (book.failures == 0 && book.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/cie_pkg.sv
src/cie_in_stage.sv
src/cie_walker.sv
src/cie_out_stage.sv
src/cigar_indel_extractor_core.sv
sim/cigar_indel_extractor_core_test.sv
